// ----- design/assert_macros.svh -----
// Assertion helpers for normal_to_hemisphere_angles.sv.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define NHA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define NHA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define NHA_ASSERT(lbl, clk, rst_n, prop)

`define NHA_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- design/nha_pkg.sv -----
`timescale 1ns / 1ps

package nha_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int SCALE_BITS    = 14;
  localparam int TABLE_LEN     = 24;

  // Signed component 2*b-255 fits in nine bits.
  localparam int COMP_W = 9;
  // x^2 + y^2 stays below 2^17.
  localparam int SQ_W   = 17;
  // Root of (x^2+y^2) * 2^(2*SCALE_BITS).
  localparam int RT_W   = (SQ_W + 1) / 2 + SCALE_BITS;
  localparam int SQP_W  = 2 * (RT_W - SCALE_BITS);
  localparam int RM_W   = RT_W + 2;
  // Vector magnitude with CORDIC gain stays below 2^24.
  localparam int CW     = 26;
  localparam int AW     = ANGLE_BITS + 2;

  // Pipeline bookkeeping, stage 0 is the input register.
  localparam int DEPTH  = RT_W + CORDIC_STAGES + 3;
  localparam int ZD_LEN = RT_W + 1;
  localparam int AZD_LEN = RT_W + 2;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [CW-1:0]     cvec_t;
  typedef logic signed [AW-1:0]     ang_t;

  localparam ang_t HALF_TURN    = ang_t'(1) << (ANGLE_BITS - 1);
  localparam ang_t QUARTER_TURN = ang_t'(1) << (ANGLE_BITS - 2);

  // atan(2^-i) in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURN32 [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Round the table entry half up to ANGLE_BITS per turn.
  function automatic ang_t stage_angle(input int i);
    logic [32:0] t;
    t = {1'b0, ATAN_TURN32[i]} + (33'd1 << (31 - ANGLE_BITS));
    return ang_t'(t >> (32 - ANGLE_BITS));
  endfunction

endpackage

// ----- design/nha_sqrt.sv -----
`timescale 1ns / 1ps

module nha_sqrt import nha_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [SQ_W-1:0] sq_in,
  output logic [RT_W-1:0] root_out
);

  logic [SQP_W-1:0] sq_r   [RT_W];
  logic [RM_W-1:0]  rem_r  [RT_W];
  logic [RT_W-1:0]  root_r [RT_W];

  // One root bit per stage, most significant first. The radicand is
  // sq_in shifted up by 2*SCALE_BITS, so the low pairs are zero.
  for (genvar k = 0; k < RT_W; k++) begin : g_step
    localparam int J = RT_W - 1 - k;
    logic [SQP_W-1:0] sq_i;
    logic [RM_W-1:0]  rem_i;
    logic [RT_W-1:0]  root_i;
    logic [1:0]       pair;
    logic [RM_W-1:0]  shifted;
    logic [RM_W-1:0]  trial;
    logic             fit;

    if (k == 0) begin : g_first
      assign sq_i   = SQP_W'(sq_in);
      assign rem_i  = '0;
      assign root_i = '0;
    end else begin : g_next
      assign sq_i   = sq_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
    end

    if (J >= SCALE_BITS) begin : g_pair
      assign pair = sq_i[2*(J-SCALE_BITS)+1 : 2*(J-SCALE_BITS)];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign shifted = {rem_i[RM_W-3:0], pair};
    assign trial   = {root_i, 2'b01};
    assign fit     = (shifted >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k]   <= sq_i;
        rem_r[k]  <= fit ? (shifted - trial) : shifted;
        root_r[k] <= {root_i[RT_W-2:0], fit};
      end
    end
  end

  assign root_out = root_r[RT_W-1];

endmodule

// ----- design/nha_cordic.sv -----
`timescale 1ns / 1ps

module nha_cordic import nha_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  cvec_t x_in,
  input  cvec_t y_in,
  input  ang_t  ang_in,
  output ang_t  ang_out
);

  cvec_t x_r [CORDIC_STAGES];
  cvec_t y_r [CORDIC_STAGES];
  ang_t  a_r [CORDIC_STAGES];

  // Vectoring mode: rotate toward y = 0 and accumulate the angle.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    cvec_t xi;
    cvec_t yi;
    ang_t  ai;
    cvec_t dx;
    cvec_t dy;

    if (i == 0) begin : g_first
      assign xi = x_in;
      assign yi = y_in;
      assign ai = ang_in;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign ai = a_r[i-1];
    end

    assign dx = yi >>> i;
    assign dy = xi >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!yi[CW-1]) begin
          x_r[i] <= xi + dx;
          y_r[i] <= yi - dy;
          a_r[i] <= ai + stage_angle(i);
        end else begin
          x_r[i] <= xi - dx;
          y_r[i] <= yi + dy;
          a_r[i] <= ai - stage_angle(i);
        end
      end
    end
  end

  assign ang_out = a_r[CORDIC_STAGES-1];

endmodule

// ----- design/normal_to_hemisphere_angles.sv -----
`timescale 1ns / 1ps
// Channel   Ports                                              Direction
// in        in_valid in_stall in_normal_x/y/z in_last_pixel    pixel in
// out       out_valid out_stall out_azimuth_code               angles out
//           out_elevation_code out_last_pixel_out
//
// One pixel per clock while in_stall is low. The stages in order are the
// input register, the squares, one root bit per stage, one register per
// CORDIC stage, the code stage and the output register.
// The azimuth CORDIC runs beside the square root; its code waits in a
// delay line. Reset clears only the valid bits, those of the output and skid too.
// A stalled result spills into a skid register; in_stall is its valid bit
// and freezes the whole pipeline until the skid drains.

`include "assert_macros.svh"

module normal_to_hemisphere_angles import nha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_normal_x,
  input  logic [7:0] in_normal_y,
  input  logic [7:0] in_normal_z,
  input  logic       in_last_pixel,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_azimuth_code,
  output logic [7:0] out_elevation_code,
  output logic       out_last_pixel_out
);

  logic             en;
  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] lst_r;

  comp_t xa_r;
  comp_t ya_r;
  comp_t za_r;

  logic [SQ_W-1:0]  sq_r;
  logic [RT_W-1:0]  root;
  comp_t            zd_r  [ZD_LEN];
  logic [CORDIC_STAGES-1:0] zn_r;
  logic [7:0]       azd_r [AZD_LEN];
  logic [7:0]       ecode_r;

  logic o_vld_r, o_vld_nxt;
  logic s_vld_r, s_vld_nxt;
  logic o_load_pipe, o_load_skid, s_load;
  logic [7:0] o_az_r, o_el_r, s_az_r, s_el_r;
  logic       o_lst_r, s_lst_r;

  assign en       = !s_vld_r;
  assign in_stall = s_vld_r;

  // Input stage: 2*b-255 is the byte with a one appended and the sign
  // bit flipped; the negated y flips the low bits instead.
  always_ff @(posedge clk) begin
    if (en) begin
      xa_r <= comp_t'({~in_normal_x[7], in_normal_x[6:0], 1'b1});
      ya_r <= comp_t'({in_normal_y[7], ~in_normal_y[6:0], 1'b1});
      za_r <= comp_t'({~in_normal_z[7], in_normal_z[6:0], 1'b1});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lst_r <= {lst_r[DEPTH-2:0], in_last_pixel};
    end
  end

  // Azimuth path: fold the left half plane over and add a half turn.
  logic  xneg;
  cvec_t ax, ay, az_x, az_y;
  ang_t  az_base, az_ang;
  logic [ANGLE_BITS-1:0] az_frac;
  logic [ANGLE_BITS+7:0] az_prod;

  assign xneg    = xa_r[COMP_W-1];
  assign ax      = cvec_t'(xa_r);
  assign ay      = cvec_t'(ya_r);
  assign az_x    = (xneg ? -ax : ax) <<< SCALE_BITS;
  assign az_y    = (xneg ? -ay : ay) <<< SCALE_BITS;
  assign az_base = xneg ? HALF_TURN : '0;

  nha_cordic u_az_cordic (
    .clk     (clk),
    .en      (en),
    .x_in    (az_x),
    .y_in    (az_y),
    .ang_in  (az_base),
    .ang_out (az_ang)
  );

  // Wrap modulo one turn, then scale by 255.
  assign az_frac = az_ang[ANGLE_BITS-1:0];
  assign az_prod = {az_frac, 8'b0} - {8'b0, az_frac};

  always_ff @(posedge clk) begin
    if (en) begin
      azd_r[0] <= az_prod[ANGLE_BITS+7:ANGLE_BITS];
      for (int k = 1; k < AZD_LEN; k++) begin
        azd_r[k] <= azd_r[k-1];
      end
    end
  end

  // Elevation path: r from the square root, then atan2(r, z).
  logic signed [2*COMP_W-1:0] xx, yy;
  logic [2*COMP_W-1:0]        ss;

  assign xx = (2*COMP_W)'(xa_r) * (2*COMP_W)'(xa_r);
  assign yy = (2*COMP_W)'(ya_r) * (2*COMP_W)'(ya_r);
  assign ss = xx + yy;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r     <= ss[SQ_W-1:0];
      zd_r[0]  <= za_r;
      for (int k = 1; k < ZD_LEN; k++) begin
        zd_r[k] <= zd_r[k-1];
      end
      zn_r     <= {zn_r[CORDIC_STAGES-2:0], zd_r[ZD_LEN-1][COMP_W-1]};
    end
  end

  nha_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .sq_in    (sq_r),
    .root_out (root)
  );

  cvec_t el_x, el_y;
  ang_t  el_ang, el_clamp, el_diff;
  logic [ANGLE_BITS-2:0] el_d;
  logic [ANGLE_BITS+6:0] el_prod;

  assign el_x = cvec_t'(zd_r[ZD_LEN-1]) <<< SCALE_BITS;
  assign el_y = cvec_t'(root);

  nha_cordic u_el_cordic (
    .clk     (clk),
    .en      (en),
    .x_in    (el_x),
    .y_in    (el_y),
    .ang_in  ('0),
    .ang_out (el_ang)
  );

  // Negative z lies below the horizon: clamp to a quarter turn, as for angles beyond it; negative angles clamp to zero.
  always_comb begin
    if (zn_r[CORDIC_STAGES-1] || (el_ang > QUARTER_TURN)) begin
      el_clamp = QUARTER_TURN;
    end else if (el_ang[AW-1]) begin
      el_clamp = '0;
    end else begin
      el_clamp = el_ang;
    end
  end

  assign el_diff = QUARTER_TURN - el_clamp;
  assign el_d    = el_diff[ANGLE_BITS-2:0];
  assign el_prod = {el_d, 8'b0} - {8'b0, el_d};

  always_ff @(posedge clk) begin
    if (en) begin
      ecode_r <= el_prod[ANGLE_BITS+5:ANGLE_BITS-2];
    end
  end

  // Output register with one skid entry behind it.
  logic take, incoming;

  assign take     = o_vld_r && !out_stall;
  assign incoming = en && vld_r[DEPTH-1];

  always_comb begin
    o_vld_nxt   = o_vld_r;
    s_vld_nxt   = s_vld_r;
    o_load_pipe = 1'b0;
    o_load_skid = 1'b0;
    s_load      = 1'b0;
    if (s_vld_r) begin
      if (take) begin
        o_load_skid = 1'b1;
        s_vld_nxt   = 1'b0;
      end
    end else if (!o_vld_r || take) begin
      o_vld_nxt   = incoming;
      o_load_pipe = incoming;
    end else if (incoming) begin
      s_vld_nxt = 1'b1;
      s_load    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
    end else begin
      o_vld_r <= o_vld_nxt;
      s_vld_r <= s_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load_pipe) begin
      o_az_r  <= azd_r[AZD_LEN-1];
      o_el_r  <= ecode_r;
      o_lst_r <= lst_r[DEPTH-1];
    end else if (o_load_skid) begin
      o_az_r  <= s_az_r;
      o_el_r  <= s_el_r;
      o_lst_r <= s_lst_r;
    end
    if (s_load) begin
      s_az_r  <= azd_r[AZD_LEN-1];
      s_el_r  <= ecode_r;
      s_lst_r <= lst_r[DEPTH-1];
    end
  end

  assign out_valid          = o_vld_r;
  assign out_azimuth_code   = o_az_r;
  assign out_elevation_code = o_el_r;
  assign out_last_pixel_out = o_lst_r;

  `NHA_ASSERT(a_skid_behind_out, clk, rst_n, s_vld_r |-> o_vld_r)
  `NHA_ASSERT(a_spill_to_skid, clk, rst_n, (incoming && o_vld_r && out_stall) |=> s_vld_r)
  `NHA_ASSERT(a_drop_after_take, clk, rst_n, $fell(out_valid) |-> ($past(!out_stall) || $past(!rst_n)))
  `NHA_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid)

endmodule
